// ----- design/sqmm_pkg.sv -----
// Shared constants and control types for the square matrix multiplier.
// Used by sqmm_ctrl, sqmm_datapath and square_matrix_multiply.
package sqmm_pkg;

   localparam int DEFAULT_MATRIX_SIZE = 4;
   localparam int IDX_W               = 2;
   localparam int VALUE_W             = 16;
   localparam int MULT_W              = 2 * VALUE_W;
   localparam int PRODUCT_W           = 34;

   // Command from controller to datapath, one per cycle.
   typedef struct packed {
      logic             load_we;     // write the request pair into both stores
      logic             issue;       // read one A/B term pair this cycle
      logic             first_term;  // first term of a dot product
      logic             last_term;   // last term of a dot product
      logic             last_entry;  // term belongs to the final product entry
      logic [IDX_W-1:0] out_row;
      logic [IDX_W-1:0] out_col;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic done;                    // final product entry is on the outputs
   } status_type;

endpackage

// ----- design/sqmm_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sqmm_ram #(
   parameter int Width = 16,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/sqmm_ctrl.sv -----
// Controller: accepts transactions, sequences the row/column/term loops of a run.
// Depends on sqmm_pkg.
module sqmm_ctrl #(
   parameter int MATRIX_SIZE = sqmm_pkg::DEFAULT_MATRIX_SIZE,
   localparam int IW = $clog2(MATRIX_SIZE),
   localparam int AW = $clog2(MATRIX_SIZE * MATRIX_SIZE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [sqmm_pkg::IDX_W-1:0]  req_row_index,
   input  logic [sqmm_pkg::IDX_W-1:0]  req_col_index,
   input  logic                        req_compute_now,
   input  sqmm_pkg::status_type        status,
   output sqmm_pkg::cmd_type           cmd,
   output logic [AW-1:0]               wr_addr,
   output logic [AW-1:0]               rd_a_addr,
   output logic [AW-1:0]               rd_b_addr
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   localparam logic [IW-1:0] LastIdx = IW'(MATRIX_SIZE - 1);

   state_type     state_ff, state_in;
   logic          busy_ff;
   logic [IW-1:0] r_ff, r_in;
   logic [IW-1:0] c_ff, c_in;
   logic [IW-1:0] k_ff, k_in;
   logic          accept;
   logic          in_range;
   logic          end_c, end_r;

   assign accept   = start && !busy_ff;
   assign in_range = (int'(req_row_index) < MATRIX_SIZE) &&
                     (int'(req_col_index) < MATRIX_SIZE);
   assign end_c    = (c_ff == LastIdx);
   assign end_r    = (r_ff == LastIdx);

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      case (state_ff)
         ST_IDLE: begin
            r_in = '0;
            c_in = '0;
            k_in = '0;
            if (accept && req_compute_now) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // advance term, then column, then row
            if (k_ff == LastIdx) begin
               k_in = '0;
               if (end_c) begin
                  c_in = '0;
                  if (end_r) begin
                     state_in = ST_DRAIN;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
      r_ff <= r_in;
      c_ff <= c_in;
      k_ff <= k_in;
   end

   assign busy = busy_ff;

   always_comb begin
      cmd.load_we    = accept && in_range;
      cmd.issue      = (state_ff == ST_RUN);
      cmd.first_term = (k_ff == '0);
      cmd.last_term  = (k_ff == LastIdx);
      cmd.last_entry = end_r && end_c;
      cmd.out_row    = sqmm_pkg::IDX_W'(r_ff);
      cmd.out_col    = sqmm_pkg::IDX_W'(c_ff);
   end

   assign wr_addr   = AW'(req_row_index) * AW'(MATRIX_SIZE) + AW'(req_col_index);
   assign rd_a_addr = AW'(r_ff) * AW'(MATRIX_SIZE) + AW'(k_ff);
   assign rd_b_addr = AW'(k_ff) * AW'(MATRIX_SIZE) + AW'(c_ff);

endmodule

// ----- design/sqmm_datapath.sv -----
// Datapath: A and B stores, multiply stage, accumulator and result registers.
// Depends on sqmm_pkg and sqmm_ram.
module sqmm_datapath #(
   parameter int MATRIX_SIZE = sqmm_pkg::DEFAULT_MATRIX_SIZE,
   localparam int AW = $clog2(MATRIX_SIZE * MATRIX_SIZE)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sqmm_pkg::cmd_type                    cmd,
   input  logic [AW-1:0]                        wr_addr,
   input  logic [AW-1:0]                        rd_a_addr,
   input  logic [AW-1:0]                        rd_b_addr,
   input  logic signed [sqmm_pkg::VALUE_W-1:0]  req_a_value,
   input  logic signed [sqmm_pkg::VALUE_W-1:0]  req_b_value,
   output sqmm_pkg::status_type                 status,
   output logic                                 rsp_strobe,
   output logic [sqmm_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [sqmm_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [sqmm_pkg::PRODUCT_W-1:0] rsp_product_value,
   output logic                                 rsp_last_entry
);

   localparam int Cells = MATRIX_SIZE * MATRIX_SIZE;

   logic [sqmm_pkg::VALUE_W-1:0]          a_rd, b_rd;
   sqmm_pkg::cmd_type                     s1_ff, s2_ff;
   logic signed [sqmm_pkg::MULT_W-1:0]    prod_ff;
   logic signed [sqmm_pkg::PRODUCT_W-1:0] acc_ff, acc_in;
   logic                                  strobe_ff;
   logic [sqmm_pkg::IDX_W-1:0]            row_ff, col_ff;
   logic                                  last_ff;

   sqmm_ram #(.Width(sqmm_pkg::VALUE_W), .Depth(Cells)) u_left_store (
      .clock   (clock),
      .wr_en   (cmd.load_we),
      .wr_addr (wr_addr),
      .wr_data (req_a_value),
      .rd_addr (rd_a_addr),
      .rd_data (a_rd)
   );

   sqmm_ram #(.Width(sqmm_pkg::VALUE_W), .Depth(Cells)) u_right_store (
      .clock   (clock),
      .wr_en   (cmd.load_we),
      .wr_addr (wr_addr),
      .wr_data (req_b_value),
      .rd_addr (rd_b_addr),
      .rd_data (b_rd)
   );

   // clear the sum on the first term, otherwise keep adding
   assign acc_in = (s2_ff.first_term ? '0 : acc_ff) +
                   sqmm_pkg::PRODUCT_W'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff     <= '0;
         s2_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         s1_ff     <= cmd;
         s2_ff     <= s1_ff;
         strobe_ff <= s2_ff.issue && s2_ff.last_term;
      end
      prod_ff <= $signed(a_rd) * $signed(b_rd);
      if (s2_ff.issue) begin
         acc_ff  <= acc_in;
         row_ff  <= s2_ff.out_row;
         col_ff  <= s2_ff.out_col;
         last_ff <= s2_ff.last_entry;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_product_value = acc_ff;
   assign rsp_last_entry    = last_ff;
   assign status.done       = strobe_ff && last_ff;

endmodule

// ----- design/square_matrix_multiply.sv -----
// Top level of the square matrix multiplier: controller plus datapath.
// Depends on sqmm_pkg, sqmm_ctrl, sqmm_datapath and sqmm_ram.
//
//  channel   handshake            payload
//  request   start / busy         req_row_index req_col_index req_a_value
//                                 req_b_value req_compute_now
//  response  rsp_strobe (1 cycle) rsp_out_row rsp_out_col rsp_product_value
//                                 rsp_last_entry
//
// A load transaction does not raise busy; busy stays low and the next one may follow.
// A compute transaction holds busy until the final product entry has been shown:
// one shared multiply-accumulate takes one term per cycle, and the product entries
// appear in row-major order, the last one marked.
// Reset clears control only; store contents are undefined until written.
// Results are shown for one cycle each and cannot be stalled.
module square_matrix_multiply #(
   parameter int MATRIX_SIZE = sqmm_pkg::DEFAULT_MATRIX_SIZE
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [sqmm_pkg::IDX_W-1:0]            req_row_index,
   input  logic [sqmm_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [sqmm_pkg::VALUE_W-1:0]   req_a_value,
   input  logic signed [sqmm_pkg::VALUE_W-1:0]   req_b_value,
   input  logic                                  req_compute_now,
   output logic                                  rsp_strobe,
   output logic [sqmm_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [sqmm_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [sqmm_pkg::PRODUCT_W-1:0] rsp_product_value,
   output logic                                  rsp_last_entry
);

   localparam int AW = $clog2(MATRIX_SIZE * MATRIX_SIZE);

   sqmm_pkg::cmd_type    cmd;
   sqmm_pkg::status_type status;
   logic [AW-1:0]        wr_addr, rd_a_addr, rd_b_addr;

   sqmm_ctrl #(.MATRIX_SIZE(MATRIX_SIZE)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .req_compute_now (req_compute_now),
      .status          (status),
      .cmd             (cmd),
      .wr_addr         (wr_addr),
      .rd_a_addr       (rd_a_addr),
      .rd_b_addr       (rd_b_addr)
   );

   sqmm_datapath #(.MATRIX_SIZE(MATRIX_SIZE)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .wr_addr           (wr_addr),
      .rd_a_addr         (rd_a_addr),
      .rd_b_addr         (rd_b_addr),
      .req_a_value       (req_a_value),
      .req_b_value       (req_b_value),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_last_entry    (rsp_last_entry)
   );

endmodule
